### rtl/opw_pkg.sv
package opw_pkg;

    localparam int PIX_W = 24;
    localparam int CH_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int IMAGE_WIDTH_W = 11;
    localparam int IMAGE_HEIGHT_W = 12;
    localparam int LEVELS_W = 5;
    localparam int BIN_STEP = 765;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY_LEVELS = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic            last_in_frame;
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
    } t_pix_out;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_BIN,
        S_ACC,
        S_SCAN,
        S_DSTART,
        S_DIV,
        S_OUT
    } t_state;

endpackage

### rtl/opw_ram.sv
module opw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/opw_div.sv
module opw_div #(
    parameter int NUM_W = 15,
    parameter int DEN_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign fits = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_quot <= {r_quot[NUM_W-2:0], fits};
            r_rem <= fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### rtl/oil_paint_window_filter.sv
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_in_data (t_pix_in)
// out       output     o_out_valid / i_out_stall o_out_data (t_pix_out)
// cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// One pixel is taken at a time. An interior pixel's time is set by the read-modify-write
// of the bin memory once per window pixel, the bin scan and the bit-serial division.
// After reset a pass clears all MAX_LEVELS+1 entries of the bin memory. A finished
// result waits in the output register while the next pixel is worked on.
module oil_paint_window_filter
    import opw_pkg::*;
#(
    parameter int RADIUS = 5,
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_LEVELS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_pix_in               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_pix_out              o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SIDE = 2 * RADIUS + 1;
    localparam int LINES = 2 * RADIUS;
    localparam int NWIN = SIDE * SIDE;
    localparam int NBINS = MAX_LEVELS + 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int LVW = $clog2(MAX_LEVELS + 1);
    localparam int BW = $clog2(NBINS);
    localparam int SBW = $clog2(NBINS + 1);
    localparam int PIW = $clog2(NWIN);
    localparam int CNTW = $clog2(NWIN + 1);
    localparam int SW = $clog2(NWIN * 255 + 1);
    localparam int HW = CNTW + 3 * SW;
    localparam int PW = 10 + LVW;
    localparam int LW = LINES * PIX_W;

    t_state r_state, n_state;

    logic [IMAGE_WIDTH_W-1:0]  r_cfg_w;
    logic [IMAGE_HEIGHT_W-1:0] r_cfg_h;
    logic [LEVELS_W-1:0]       r_cfg_lv;

    logic [CW-1:0]             w_eff;
    logic [IMAGE_HEIGHT_W-1:0] h_eff;
    logic [LVW-1:0]            lv_eff;

    logic [CW-1:0]             r_col, col_eff, col_nx;
    logic [IMAGE_HEIGHT_W-1:0] r_row, row_eff, row_nx;
    t_pix_in                   r_pix;
    logic                      r_last;
    t_pix_in                   r_win [NWIN];
    t_pix_in                   r_cur;
    logic [PW-1:0]             r_prod;
    logic [BW-1:0]             r_bin;
    logic [MAX_LEVELS-1:0]     above;
    logic [PIW-1:0]            r_pidx;
    logic [SBW-1:0]            r_sidx;
    logic [HW-1:0]             r_best;
    logic [CNTW-1:0]           best_cnt;

    logic                      line_we;
    logic [LW-1:0]             line_q;
    logic                      hist_we;
    logic [BW-1:0]             hist_waddr, hist_raddr;
    logic [HW-1:0]             hist_wdata, hist_q;

    logic                      div_start;
    logic [CNTW-1:0]           div_den;
    logic [2:0]                div_done;
    logic [SW-1:0]             quot [3];

    t_pix_out                  r_out;
    logic                      r_out_valid;
    logic                      out_free;
    logic                      emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= IMAGE_WIDTH_W'(512);
            r_cfg_h <= IMAGE_HEIGHT_W'(512);
            r_cfg_lv <= LEVELS_W'(20);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH: r_cfg_w <= i_cfg_data[IMAGE_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data[IMAGE_HEIGHT_W-1:0];
                CFG_INTENSITY_LEVELS: r_cfg_lv <= i_cfg_data[LEVELS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else if (r_cfg_w == '0) begin
            w_eff = CW'(1);
        end else begin
            w_eff = CW'(r_cfg_w);
        end
        h_eff = (r_cfg_h == '0) ? IMAGE_HEIGHT_W'(1) : r_cfg_h;
        if (32'(r_cfg_lv) > 32'(MAX_LEVELS)) begin
            lv_eff = LVW'(MAX_LEVELS);
        end else begin
            lv_eff = LVW'(r_cfg_lv);
        end
    end

    // A size change in mid-frame can leave the column past the row end.
    always_comb begin
        col_eff = r_col;
        row_eff = r_row;
        if (r_col >= w_eff) begin
            col_eff = '0;
            row_eff = ({1'b0, r_row} + 1'b1 >= {1'b0, h_eff}) ? '0 : r_row + 1'b1;
        end
        col_nx = r_col + 1'b1;
        row_nx = r_row;
        if (col_nx >= w_eff) begin
            col_nx = '0;
            row_nx = ({1'b0, r_row} + 1'b1 >= {1'b0, h_eff}) ? '0 : r_row + 1'b1;
        end
    end

    assign emit = (32'(r_row) >= 32'(LINES)) && (32'(r_col) >= 32'(LINES));

    always_comb begin
        for (int k = 1; k <= MAX_LEVELS; k++) begin
            above[k-1] = 32'(r_prod) >= 32'(BIN_STEP * k);
        end
    end

    assign best_cnt = r_best[CNTW-1:0];
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_in_stall = 1'b1;
        line_we = 1'b0;
        hist_we = 1'b0;
        hist_waddr = r_bin;
        hist_wdata = '0;
        hist_raddr = r_sidx[BW-1:0];
        div_start = 1'b0;
        unique case (r_state)
            S_CLR: begin
                hist_we = 1'b1;
                hist_waddr = r_sidx[BW-1:0];
                if (r_sidx == SBW'(NBINS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                line_we = 1'b1;
                n_state = emit ? S_MUL : S_IDLE;
            end
            S_MUL: begin
                n_state = S_BIN;
            end
            S_BIN: begin
                hist_raddr = BW'($countones(above));
                n_state = S_ACC;
            end
            S_ACC: begin
                hist_we = 1'b1;
                hist_wdata[CNTW-1:0] = hist_q[CNTW-1:0] + 1'b1;
                hist_wdata[CNTW+:SW] = hist_q[CNTW+:SW] + SW'(r_cur.blue);
                hist_wdata[CNTW+SW+:SW] = hist_q[CNTW+SW+:SW] + SW'(r_cur.green);
                hist_wdata[CNTW+2*SW+:SW] = hist_q[CNTW+2*SW+:SW] + SW'(r_cur.red);
                n_state = (r_pidx == PIW'(NWIN - 1)) ? S_SCAN : S_MUL;
            end
            S_SCAN: begin
                if (r_sidx != '0) begin
                    hist_we = 1'b1;
                    hist_waddr = BW'(r_sidx - 1'b1);
                end
                if (r_sidx == SBW'(NBINS)) begin
                    n_state = S_DSTART;
                end
            end
            S_DSTART: begin
                div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done[0]) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_sidx <= '0;
            r_col <= '0;
            r_row <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: r_sidx <= r_sidx + 1'b1;
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_col <= col_eff;
                        r_row <= row_eff;
                    end
                end
                S_LOAD: begin
                    r_col <= col_nx;
                    r_row <= row_nx;
                end
                S_ACC: r_sidx <= '0;
                S_SCAN: r_sidx <= r_sidx + 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: r_pix <= i_in_data;
            S_LOAD: begin
                for (int i = 0; i < NWIN - SIDE; i++) begin
                    r_win[i] <= r_win[i+SIDE];
                end
                for (int y = 0; y < LINES; y++) begin
                    r_win[NWIN-SIDE+y] <= line_q[y*PIX_W+:PIX_W];
                end
                r_win[NWIN-1] <= r_pix;
                r_last <= (r_row == h_eff - 1'b1) && (r_col == w_eff - 1'b1);
                r_pidx <= '0;
            end
            S_MUL: begin
                r_cur <= r_win[0];
                r_prod <= PW'(10'(r_win[0].blue) + 10'(r_win[0].green)
                              + 10'(r_win[0].red)) * PW'(lv_eff);
            end
            S_BIN: r_bin <= BW'($countones(above));
            S_ACC: begin
                for (int i = 0; i < NWIN - 1; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[NWIN-1] <= r_win[0];
                r_pidx <= r_pidx + 1'b1;
                r_best <= '0;
            end
            S_SCAN: begin
                if (r_sidx != '0 && hist_q[CNTW-1:0] > best_cnt) begin
                    r_best <= hist_q;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_out.out_blue <= quot[0][CH_W-1:0];
                    r_out.out_green <= quot[1][CH_W-1:0];
                    r_out.out_red <= quot[2][CH_W-1:0];
                    r_out.last_in_frame <= r_last;
                end
            end
            default: ;
        endcase
    end

    opw_ram #(
        .WIDTH(LW),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .i_clk  (i_clk),
        .i_we   (line_we),
        .i_waddr(r_col[AW-1:0]),
        .i_wdata({r_pix, line_q[LW-1:PIX_W]}),
        .i_raddr(col_eff[AW-1:0]),
        .o_rdata(line_q)
    );

    opw_ram #(
        .WIDTH(HW),
        .DEPTH(NBINS)
    ) u_hist_ram (
        .i_clk  (i_clk),
        .i_we   (hist_we),
        .i_waddr(hist_waddr),
        .i_wdata(hist_wdata),
        .i_raddr(hist_raddr),
        .o_rdata(hist_q)
    );

    assign div_den = (best_cnt == '0) ? CNTW'(1) : best_cnt;

    for (genvar c = 0; c < 3; c++) begin : g_div
        opw_div #(
            .NUM_W(SW),
            .DEN_W(CNTW)
        ) u_div (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_start(div_start),
            .i_num  (r_best[CNTW+c*SW+:SW]),
            .i_den  (div_den),
            .o_done (div_done[c]),
            .o_quot (quot[c])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

endmodule

### test/oil_paint_window_filter_checker.sv
module oil_paint_window_filter_checker
    import opw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_pix_in               i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_pix_out              i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAD = 5;
    localparam int SIDE = 2 * RAD + 1;
    localparam int LINES = 2 * RAD;
    localparam int WMAX = 1024;
    localparam int LMAX = 20;

    logic [IMAGE_WIDTH_W-1:0]  img_w;
    logic [IMAGE_HEIGHT_W-1:0] img_h;
    logic [LEVELS_W-1:0]       levels;
    logic [PIX_W-1:0]          line_buf [LINES][WMAX];
    logic [PIX_W-1:0]          window [SIDE][SIDE];
    int unsigned               col_pos;
    int unsigned               row_pos;
    t_pix_out                  mean_q [$];

    task automatic next_row(input int unsigned h);
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) begin
            row_pos = 0;
        end
    endtask

    task automatic predict_mean(input t_pix_in px);
        int unsigned w, h, lev, col, bin, top, topcnt;
        int unsigned cnt [LMAX+1];
        int unsigned sum [LMAX+1][3];
        logic [7:0] b, g, r;
        bit emit, last;
        t_pix_out res;
        w = img_w;
        h = img_h;
        lev = levels;
        if (w > WMAX) w = WMAX;
        if (w == 0) w = 1;
        if (h == 0) h = 1;
        if (lev > LMAX) lev = LMAX;
        if (col_pos >= w) next_row(h);
        col = col_pos;
        for (int x = 0; x < SIDE - 1; x++) begin
            for (int y = 0; y < SIDE; y++) begin
                window[x][y] = window[x+1][y];
            end
        end
        for (int k = 0; k < LINES; k++) begin
            window[SIDE-1][k] = line_buf[k][col];
        end
        window[SIDE-1][LINES] = px;
        for (int k = 0; k < LINES - 1; k++) begin
            line_buf[k][col] = line_buf[k+1][col];
        end
        line_buf[LINES-1][col] = px;
        emit = (row_pos >= LINES) && (col >= LINES);
        last = (row_pos == h - 1) && (col == w - 1);
        col_pos = col + 1;
        if (col_pos >= w) next_row(h);
        if (!emit) return;
        for (int k = 0; k <= LMAX; k++) begin
            cnt[k] = 0;
            sum[k] = '{0, 0, 0};
        end
        for (int x = 0; x < SIDE; x++) begin
            for (int y = 0; y < SIDE; y++) begin
                {r, g, b} = window[x][y];
                bin = ((b + g + r) * lev) / BIN_STEP;
                if (bin > LMAX) bin = LMAX;
                cnt[bin]++;
                sum[bin][0] += b;
                sum[bin][1] += g;
                sum[bin][2] += r;
            end
        end
        top = 0;
        topcnt = 0;
        for (int k = 0; k <= LMAX; k++) begin
            if (cnt[k] > topcnt) begin
                topcnt = cnt[k];
                top = k;
            end
        end
        if (topcnt == 0) topcnt = 1;
        res.out_blue = 8'(sum[top][0] / topcnt);
        res.out_green = 8'(sum[top][1] / topcnt);
        res.out_red = 8'(sum[top][2] / topcnt);
        res.last_in_frame = last;
        mean_q.insert(mean_q.size(), res);
    endtask

    always @(posedge i_clk) begin
        t_pix_out want;
        if (!i_rst_n) begin
            img_w = 512;
            img_h = 512;
            levels = 20;
            col_pos = 0;
            row_pos = 0;
            mean_q.delete();
            o_errors = 0;
            o_pending = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH: begin
                        img_w = i_cfg_data[IMAGE_WIDTH_W-1:0];
                    end
                    CFG_IMAGE_HEIGHT: begin
                        img_h = i_cfg_data[IMAGE_HEIGHT_W-1:0];
                    end
                    CFG_INTENSITY_LEVELS: begin
                        levels = i_cfg_data[LEVELS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (mean_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("unexpected result transfer: %h", i_out_data);
                    end
                end else begin
                    want = mean_q.pop_front();
                    if (want.out_blue !== i_out_data.out_blue ||
                        want.out_green !== i_out_data.out_green ||
                        want.out_red !== i_out_data.out_red ||
                        want.last_in_frame !== i_out_data.last_in_frame) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("mismatch: expected %h, got %h", want, i_out_data);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_mean(i_in_data);
            end
            o_pending = mean_q.size();
        end
    end
endmodule

### test/oil_paint_window_filter_tb.sv
module oil_paint_window_filter_tb
    import opw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_pix_in               in_data;
    logic                  out_valid;
    logic                  out_stall;
    t_pix_out              out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    quiet_cycles;
    bit                    calm;

    oil_paint_window_filter DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    oil_paint_window_filter_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < 19);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("oil_paint_window_filter_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_pix_in rand_pixel();
        t_pix_in px;
        logic [7:0] base;
        base = 8'($urandom);
        case ($urandom_range(9))
            0: px = '0;
            1: px = '1;
            2: px = {{8{$urandom_range(1) == 1}}, {8{$urandom_range(1) == 1}},
                     {8{$urandom_range(1) == 1}}};
            3, 4: px = {base ^ 8'($urandom_range(3)), base ^ 8'($urandom_range(3)),
                        base ^ 8'($urandom_range(3))};
            default: px = 24'($urandom);
        endcase
        return px;
    endfunction

    task automatic send_pixel(input t_pix_in px);
        while (!calm && $urandom_range(99) < 19) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = px;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic set_image(input int unsigned w, input int unsigned h,
                             input int unsigned lev);
        drain();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_INTENSITY_LEVELS, lev);
    endtask

    initial begin
        t_pix_in edge_px [15];
        int unsigned w, h, lev;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data = '0;
        calm = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // One full frame at the widest row used below fills every line-buffer column the tests use.
        set_image(24, 11, 20);
        for (int i = 0; i < 24 * 11; i++) begin
            send_pixel(rand_pixel());
        end
        edge_px = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                    24'hFFFFFF, 24'h000000, 24'h808080, 24'h7F7F7F, 24'h010101,
                    24'hFEFEFE, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h555555};
        foreach (edge_px[i]) begin
            send_pixel(edge_px[i]);
        end

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin w = 11; h = 11; lev = 1; end
                1: begin w = 11; h = 12; lev = 20; end
                2: begin w = 16; h = 11; lev = 7; end
                default: begin
                    w = $urandom_range(11, 24);
                    h = $urandom_range(11, 16);
                    lev = $urandom_range(1, 20);
                end
            endcase
            set_image(w, h, lev);
            calm = (ph == 2);
            for (int i = 0; i < 109; i++) begin
                send_pixel(rand_pixel());
            end
        end
        calm = 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (500) @(negedge clk);
        if (errors == 0) begin
            $display("oil_paint_window_filter_tb: done, clean");
        end else begin
            $display("oil_paint_window_filter_tb: done, errors");
        end
        $finish;
    end
endmodule
